// ----- sv/bme_pkg.sv -----
package bme_pkg;

	// default sizing
	localparam int MAX_DEGREE_DEF = 8;
	localparam int FRAC_BITS_DEF  = 16;

	// fixed field widths
	localparam int VAL_W  = 32;
	localparam int DEG_W  = 4;
	localparam int PROD_W = 2 * VAL_W;

	// register file: one register, byte address 4*i
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam logic REG_POLY_DEGREE = 1'b0;

	// poly_degree after reset
	localparam logic [DEG_W-1:0] POLY_DEGREE_RST = 4'd1;

	// saturation bounds of the 32-bit result
	localparam logic signed [PROD_W-1:0] VAL_MAX = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] VAL_MIN = -64'sd2147483648;

	// one row buffer entry: value plus sticky overflow
	typedef struct packed {
		logic                    ovf;
		logic signed [VAL_W-1:0] val;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_FETCH,
		ST_MUL,
		ST_WRITE
	} state_t;

endpackage

// ----- sv/bme_ram.sv -----
module bme_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/bme_mul.sv -----
module bme_mul #(
	parameter int FRAC_BITS = bme_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             en,
	input  bme_pkg::cell_t                   operand,
	input  logic signed [bme_pkg::VAL_W-1:0] factor,
	output bme_pkg::cell_t                   result
);
	import bme_pkg::*;

	localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod_s2;
	logic                     ovf_s2;
	logic signed [PROD_W-1:0] rnd;
	logic signed [PROD_W-1:0] shr;
	logic                     sat_hi;
	logic                     sat_lo;

	// full-width signed product, registered
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(operand.val) * PROD_W'(factor);
			ovf_s2  <= operand.ovf;
		end
	end

	// round half up (floor after adding half an LSB), then clamp
	always_comb begin
		rnd    = prod_s2 + HALF_LSB;
		shr    = rnd >>> FRAC_BITS;
		sat_hi = shr > VAL_MAX;
		sat_lo = shr < VAL_MIN;
		result.ovf = ovf_s2 | sat_hi | sat_lo;
		if (sat_hi) begin
			result.val = VAL_MAX[VAL_W-1:0];
		end else if (sat_lo) begin
			result.val = VAL_MIN[VAL_W-1:0];
		end else begin
			result.val = shr[VAL_W-1:0];
		end
	end

endmodule

// ----- sv/bivariate_monomial_expander.sv -----
// Sequence: after the input transfer the constant term is loaded into the output register.
// The second term then follows a RAM read, a multiply and a round/write-back.
// Each further term then takes a multiply, then round/write-back and output
// load, paced by the single shared multiplier and the row RAM port.
// A point has T = (D+1)(D+2)/2 terms; a new point is accepted only after its last
// term is loaded, and m_tready stalls hold the sequencer. Reset clears the sequencer, output valid
// and poly_degree (to 1); row RAM is not cleared.
module bivariate_monomial_expander #(
	parameter int MAX_DEGREE = bme_pkg::MAX_DEGREE_DEF,
	parameter int FRAC_BITS  = bme_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,  // [31:0] x_value, [63:32] y_value
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [39:0]                   m_tdata,  // [31:0] term_value, [35:32] term_degree,
	                                                // [39:36] y_power
	output logic                          m_tuser,  // [0] overflow
	output logic                          m_tlast,  // last_term
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bme_pkg::APB_AW-1:0]    paddr,
	input  logic [bme_pkg::APB_DW-1:0]    pwdata,
	output logic [bme_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import bme_pkg::*;

	localparam int DEPTH = MAX_DEGREE + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [DEG_W-1:0] DEG_LIMIT = DEG_W'(MAX_DEGREE);
	localparam logic signed [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;
	localparam cell_t ONE_CELL = '{ovf: 1'b0, val: ONE_VAL};

	state_t state_q, state_d;

	logic [DEG_W-1:0]        poly_degree_q;
	logic [DEG_W-1:0]        dmax_q;
	logic [DEG_W-1:0]        deg_q;
	logic [DEG_W-1:0]        term_q;
	logic signed [VAL_W-1:0] x_q;
	logic signed [VAL_W-1:0] y_q;
	cell_t                   saved_q;

	logic                    m_tvalid_q;
	cell_t                   out_cell_q;
	logic [DEG_W-1:0]        out_deg_q;
	logic [DEG_W-1:0]        out_yp_q;
	logic                    out_last_q;

	logic                    cfg_wr;
	logic                    out_free;
	logic                    row_end;
	logic                    advance;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	cell_t                   ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [CELL_W-1:0]       ram_rdata;
	cell_t                   rd_cell;

	logic                    mul_en;
	cell_t                   mul_opnd;
	logic signed [VAL_W-1:0] mul_fac;
	cell_t                   mul_res;

	logic                    out_load;
	cell_t                   out_cell;
	logic [DEG_W-1:0]        out_deg;
	logic [DEG_W-1:0]        out_yp;
	logic                    out_last;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[APB_AW-1:2] == REG_POLY_DEGREE);
	assign prdata = (paddr[APB_AW-1:2] == REG_POLY_DEGREE) ?
		{{(APB_DW-DEG_W){1'b0}}, poly_degree_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_degree_q <= POLY_DEGREE_RST;
		end else if (cfg_wr) begin
			poly_degree_q <= pwdata[DEG_W-1:0];
		end
	end

	// row buffer memory
	bme_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_row (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_cell = ram_rdata;

	// last term of a row reuses the old neighbor and multiplies by y
	assign row_end  = (term_q == deg_q);
	assign mul_opnd = row_end ? saved_q : rd_cell;
	assign mul_fac  = row_end ? y_q : x_q;

	bme_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.en     (mul_en),
		.operand(mul_opnd),
		.factor (mul_fac),
		.result (mul_res)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// sequencer: next state, RAM and output control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = term_q[AW-1:0];
		ram_wdata = mul_res;
		ram_re    = 1'b0;
		ram_raddr = '0;
		mul_en    = 1'b0;
		out_load  = 1'b0;
		out_cell  = mul_res;
		out_deg   = deg_q;
		out_yp    = term_q;
		out_last  = 1'b0;
		advance   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (out_free) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = ONE_CELL;
					out_load  = 1'b1;
					out_cell  = ONE_CELL;
					out_deg   = '0;
					out_yp    = '0;
					out_last  = (dmax_q == '0);
					state_d   = (dmax_q == '0) ? ST_IDLE : ST_FETCH;
				end
			end
			ST_FETCH: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				mul_en  = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free) begin
					ram_we   = 1'b1;
					out_load = 1'b1;
					out_last = (deg_q == dmax_q) && row_end;
					if (out_last) begin
						state_d = ST_IDLE;
					end else begin
						// prefetch next operand; never the entry being written
						ram_re    = 1'b1;
						ram_raddr = row_end ? '0 : AW'(term_q + 4'd1);
						advance   = 1'b1;
						state_d   = ST_MUL;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// degree and term counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q  <= '0;
			term_q <= '0;
			dmax_q <= '0;
		end else if (s_tvalid && s_tready) begin
			deg_q  <= 4'd1;
			term_q <= '0;
			dmax_q <= (poly_degree_q > DEG_LIMIT) ? DEG_LIMIT : poly_degree_q;
		end else if (advance) begin
			if (row_end) begin
				deg_q  <= deg_q + 4'd1;
				term_q <= '0;
			end else begin
				term_q <= term_q + 4'd1;
			end
		end
	end

	// point operands and old row entry held for the y product
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_q <= s_tdata[31:0];
			y_q <= s_tdata[63:32];
		end
		if (state_q == ST_MUL && !row_end) begin
			saved_q <= rd_cell;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_cell_q <= out_cell;
			out_deg_q  <= out_deg;
			out_yp_q   <= out_yp;
			out_last_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_yp_q, out_deg_q, out_cell_q.val};
	assign m_tuser  = out_cell_q.ovf;
	assign m_tlast  = out_last_q;

	// checks
	a_term_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_WRITE) |-> (term_q <= deg_q))
		else $error("term index beyond current degree");

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_WRITE) |-> (deg_q != '0 && deg_q <= dmax_q))
		else $error("degree counter out of range");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("row RAM read and write to same entry");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last) |=> (state_q == ST_IDLE && m_tvalid && m_tlast))
		else $error("last term did not end the point");

endmodule
